// File: rtl/core/czs_pkg.sv
package czs_pkg;

    localparam int WIN = 10;
    localparam int MAX_WORD_LENGTH = 255;
    localparam int CNT_W = $clog2(MAX_WORD_LENGTH + 1);

    localparam logic [15:0] CH_A_ACUTE = 16'h00E1;
    localparam logic [15:0] CH_E_ACUTE = 16'h00E9;
    localparam logic [15:0] CH_I_ACUTE = 16'h00ED;
    localparam logic [15:0] CH_Y_ACUTE = 16'h00FD;
    localparam logic [15:0] CH_C_CARON = 16'h010D;
    localparam logic [15:0] CH_E_CARON = 16'h011B;
    localparam logic [15:0] CH_S_CARON = 16'h0161;
    localparam logic [15:0] CH_U_RING  = 16'h016F;
    localparam logic [15:0] CH_Z_CARON = 16'h017E;

    typedef struct packed {
        logic [15:0] char_code;
        logic        word_end;
    } czs_in_t;

    typedef struct packed {
        logic [7:0]  stem_length;
        logic [15:0] stem_last_char;
        logic [15:0] stem_prev_char;
    } czs_out_t;

    typedef logic [15:0] czs_win_t [WIN];

    function automatic logic [15:0] ch8(input logic [7:0] c);
        return {8'd0, c};
    endfunction

    // True when the stem ending at exclusive end e (in window a) matches s[0..n-1].
    function automatic logic ends3(input czs_win_t a, input int e, input int n,
                                   input logic [15:0] s0, input logic [15:0] s1,
                                   input logic [15:0] s2);
        logic ok;
        logic [15:0] s [3];
        ok = (e - n >= 0);
        s[0] = s0;
        s[1] = s1;
        s[2] = s2;
        for (int j = 0; j < 3; j++)
        begin
            if (j < n && ok)
            begin
                if (a[e - n + j] != s[j])
                    ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Length of the case ending that applies, 0 when none.
    function automatic logic [2:0] case_len(input czs_win_t a, input logic [CNT_W-1:0] len);
        logic [2:0] r;
        logic m5, m4, m3, m2, m1;
        logic [15:0] x0, x1, x2;
        x0 = a[WIN-3];
        x1 = a[WIN-2];
        x2 = a[WIN-1];
        m5 = a[WIN-5] == ch8("a") && a[WIN-4] == ch8("t") && x0 == ch8("e")
             && x1 == ch8("c") && x2 == ch8("h");
        m4 = (a[WIN-4] == CH_E_CARON || a[WIN-4] == ch8("e")) && x0 == ch8("t")
             && x1 == ch8("e") && x2 == ch8("m");
        m4 = m4 || (a[WIN-4] == ch8("a") && x0 == ch8("t") && x1 == CH_U_RING
             && x2 == ch8("m"));
        m3 = (x1 == ch8("c") && x2 == ch8("h") && (x0 == ch8("e") || x0 == ch8("i")
              || x0 == CH_I_ACUTE || x0 == CH_A_ACUTE || x0 == CH_Y_ACUTE))
          || ((x0 == CH_E_ACUTE || x0 == CH_I_ACUTE || x0 == ch8("i"))
              && x1 == ch8("h") && x2 == ch8("o"))
          || ((x0 == CH_E_CARON || x0 == ch8("e") || x0 == CH_I_ACUTE || x0 == ch8("a")
              || x0 == CH_Y_ACUTE) && x1 == ch8("m") && x2 == ch8("i"))
          || ((x0 == CH_E_ACUTE || x0 == CH_I_ACUTE || x0 == ch8("i"))
              && x1 == ch8("m") && x2 == ch8("u"))
          || ((x0 == CH_E_CARON || x0 == ch8("e")) && x1 == ch8("t")
              && (x2 == ch8("e") || x2 == ch8("i")))
          || (x0 == ch8("a") && x1 == ch8("t") && (x2 == ch8("a") || x2 == ch8("y")))
          || (x0 == ch8("a") && x1 == ch8("m") && x2 == ch8("a"))
          || (x0 == ch8("o") && x1 == ch8("v") && (x2 == CH_E_ACUTE || x2 == ch8("i")));
        m2 = (x2 == ch8("m") && (x1 == ch8("e") || x1 == CH_E_ACUTE || x1 == CH_I_ACUTE
              || x1 == CH_U_RING || x1 == CH_A_ACUTE || x1 == CH_Y_ACUTE))
          || (x2 == ch8("s") && (x1 == ch8("e") || x1 == ch8("o") || x1 == ch8("u")))
          || (x1 == ch8("a") && x2 == ch8("t"))
          || (x1 == ch8("m") && x2 == ch8("i"))
          || (x1 == ch8("o") && x2 == ch8("u"));
        m1 = x2 == ch8("a") || x2 == ch8("e") || x2 == ch8("i") || x2 == ch8("o")
          || x2 == ch8("u") || x2 == CH_U_RING || x2 == ch8("y") || x2 == CH_A_ACUTE
          || x2 == CH_E_ACUTE || x2 == CH_I_ACUTE || x2 == CH_Y_ACUTE
          || x2 == CH_E_CARON;
        if (m5 && len > CNT_W'(7))
            r = 3'd5;
        else if (m4 && len > CNT_W'(6))
            r = 3'd4;
        else if (m3 && len > CNT_W'(5))
            r = 3'd3;
        else if (m2 && len > CNT_W'(4))
            r = 3'd2;
        else if (m1 && len > CNT_W'(3))
            r = 3'd1;
        else
            r = 3'd0;
        return r;
    endfunction

endpackage

// File: rtl/core/czs_cell.sv
module czs_cell
    import czs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift,
    input  logic        clear,
    input  logic [15:0] din,
    output logic [15:0] dout
);

    logic [15:0] data_reg;
    logic [15:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (clear)
            data_next = '0;
        else if (shift)
            data_next = din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else
            data_reg <= data_next;
    end

    assign dout = data_reg;

endmodule

// File: rtl/core/czs_stem.sv
module czs_stem
    import czs_pkg::*;
(
    input  czs_win_t         a_in,
    input  logic [CNT_W-1:0] len_in,
    output czs_out_t         res
);

    always_comb
    begin
        czs_win_t a;
        int e;
        int len;
        int k;
        logic [15:0] p;
        logic [15:0] l;
        a = a_in;
        len = int'(len_in);
        k = int'(case_len(a, len_in));
        e = WIN - k;
        len = len - k;
        if (len > 5)
        begin
            if (ends3(a, e, 2, ch8("o"), ch8("v"), 16'd0)
                || ends3(a, e, 2, ch8("i"), ch8("n"), 16'd0)
                || ends3(a, e, 2, CH_U_RING, ch8("v"), 16'd0))
            begin
                len = len - 2;
                e = e - 2;
            end
        end
        p = a[e-2];
        l = a[e-1];
        if (len > 0)
        begin
            if (len >= 2 && l == ch8("t") && p == CH_C_CARON)
            begin
                a[e-2] = ch8("c");
                a[e-1] = ch8("k");
            end
            else if (len >= 2 && l == ch8("t") && p == CH_S_CARON)
            begin
                a[e-2] = ch8("s");
                a[e-1] = ch8("k");
            end
            else if (l == ch8("c") || l == CH_C_CARON)
                a[e-1] = ch8("k");
            else if (l == ch8("z") || l == CH_Z_CARON)
                a[e-1] = ch8("h");
            else if (len > 1 && p == ch8("e"))
            begin
                a[e-2] = l;
                len = len - 1;
                e = e - 1;
            end
            else if (len > 2 && p == CH_U_RING)
                a[e-2] = ch8("o");
        end
        res.stem_length = (len > 255) ? 8'd255 : 8'(len);
        res.stem_last_char = (len >= 1) ? a[e-1] : 16'd0;
        res.stem_prev_char = (len >= 2) ? a[e-2] : 16'd0;
    end

endmodule

// File: rtl/core/czech_suffix_stemmer.sv
// Result: the stem appears in the output register in the cycle after the final character is accepted.
// Throughput: one character per cycle; the ten-cell shift chain takes a character
// every cycle unless the output register holds a result that has not been taken.
// Reset: rst_n clears the character chain, the length counter and the output valid.
module czech_suffix_stemmer
    import czs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  czs_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output czs_out_t out_data
);

    czs_win_t         win;
    logic             acc;
    logic             fin;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic             ov_reg, ov_next;
    czs_out_t         od_reg, res;
    czs_win_t         a_new;

    assign in_ready = !ov_reg || out_ready;
    assign acc = in_valid && in_ready;
    assign fin = acc && in_data.word_end;

    genvar g;
    generate
        for (g = 0; g < WIN; g++)
        begin : g_cell
            czs_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (acc),
                .clear (fin),
                .din   ((g == 0) ? in_data.char_code : win[(g == 0) ? 0 : g - 1]),
                .dout  (win[g])
            );
        end
    endgenerate

    always_comb
    begin
        for (int k = 0; k < WIN; k++)
        begin
            if (k == WIN - 1)
                a_new[k] = in_data.char_code;
            else
                a_new[k] = win[WIN - 2 - k];
        end
        cnt_inc = (cnt_reg < CNT_W'(MAX_WORD_LENGTH)) ? cnt_reg + 1'b1 : cnt_reg;
        cnt_next = cnt_reg;
        if (fin)
            cnt_next = '0;
        else if (acc)
            cnt_next = cnt_inc;
        ov_next = ov_reg;
        if (fin)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    czs_stem u_stem (
        .a_in   (a_new),
        .len_in (cnt_inc),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
            od_reg <= res;
    end

    assign out_valid = ov_reg;
    assign out_data = od_reg;

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.stem_length != 8'd0)
        else $error("stem length zero");
    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> cnt_reg == '0)
        else $error("length not cleared");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");

endmodule

// File: bench/czech_suffix_stemmer_tb.sv
module czech_suffix_stemmer_tb;
    import czs_pkg::*;

    localparam int N_RANDOM = 690;
    localparam int STALL_LIMIT = 4000;
    localparam int CALM_ITEMS = 120;
    localparam int N_ENDINGS = 53;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    czs_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    czs_out_t out_data;

    czech_suffix_stemmer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    typedef struct {
        logic [15:0] code;
        logic        last;
        logic        known;
        czs_out_t    want;
    } stim_row_t;

    logic [15:0] tail_chars [WIN];
    int          char_count;
    czs_out_t    stems_due [$];
    stim_row_t   requests [$];
    int          errors;
    int          mismatches;
    int          idle_cycles;
    int          ready_gap;
    bit          calm;
    bit          hold_off;
    bit          sending_done;
    logic [15:0] endings [N_ENDINGS][5];
    int          ending_len [N_ENDINGS];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [15:0] u(input logic [7:0] c);
        return {8'd0, c};
    endfunction

    task automatic add_ending(input int idx, input int n, input logic [15:0] c0,
                              input logic [15:0] c1, input logic [15:0] c2,
                              input logic [15:0] c3, input logic [15:0] c4);
        ending_len[idx] = n;
        endings[idx][0] = c0;
        endings[idx][1] = c1;
        endings[idx][2] = c2;
        endings[idx][3] = c3;
        endings[idx][4] = c4;
    endtask

    initial
    begin
        add_ending(0, 5, u("a"), u("t"), u("e"), u("c"), u("h"));
        add_ending(1, 4, CH_E_CARON, u("t"), u("e"), u("m"), 0);
        add_ending(2, 4, u("e"), u("t"), u("e"), u("m"), 0);
        add_ending(3, 4, u("a"), u("t"), CH_U_RING, u("m"), 0);
        add_ending(4, 3, u("e"), u("c"), u("h"), 0, 0);
        add_ending(5, 3, u("i"), u("c"), u("h"), 0, 0);
        add_ending(6, 3, CH_I_ACUTE, u("c"), u("h"), 0, 0);
        add_ending(7, 3, CH_E_ACUTE, u("h"), u("o"), 0, 0);
        add_ending(8, 3, CH_E_CARON, u("m"), u("i"), 0, 0);
        add_ending(9, 3, u("e"), u("m"), u("i"), 0, 0);
        add_ending(10, 3, CH_E_ACUTE, u("m"), u("u"), 0, 0);
        add_ending(11, 3, CH_E_CARON, u("t"), u("e"), 0, 0);
        add_ending(12, 3, u("e"), u("t"), u("e"), 0, 0);
        add_ending(13, 3, CH_E_CARON, u("t"), u("i"), 0, 0);
        add_ending(14, 3, u("e"), u("t"), u("i"), 0, 0);
        add_ending(15, 3, CH_I_ACUTE, u("h"), u("o"), 0, 0);
        add_ending(16, 3, u("i"), u("h"), u("o"), 0, 0);
        add_ending(17, 3, CH_I_ACUTE, u("m"), u("i"), 0, 0);
        add_ending(18, 3, CH_I_ACUTE, u("m"), u("u"), 0, 0);
        add_ending(19, 3, u("i"), u("m"), u("u"), 0, 0);
        add_ending(20, 3, CH_A_ACUTE, u("c"), u("h"), 0, 0);
        add_ending(21, 3, u("a"), u("t"), u("a"), 0, 0);
        add_ending(22, 3, u("a"), u("t"), u("y"), 0, 0);
        add_ending(23, 3, CH_Y_ACUTE, u("c"), u("h"), 0, 0);
        add_ending(24, 3, u("a"), u("m"), u("a"), 0, 0);
        add_ending(25, 3, u("a"), u("m"), u("i"), 0, 0);
        add_ending(26, 3, u("o"), u("v"), CH_E_ACUTE, 0, 0);
        add_ending(27, 3, u("o"), u("v"), u("i"), 0, 0);
        add_ending(28, 3, CH_Y_ACUTE, u("m"), u("i"), 0, 0);
        add_ending(29, 2, u("e"), u("m"), 0, 0, 0);
        add_ending(30, 2, u("e"), u("s"), 0, 0, 0);
        add_ending(31, 2, CH_E_ACUTE, u("m"), 0, 0, 0);
        add_ending(32, 2, CH_I_ACUTE, u("m"), 0, 0, 0);
        add_ending(33, 2, CH_U_RING, u("m"), 0, 0, 0);
        add_ending(34, 2, u("a"), u("t"), 0, 0, 0);
        add_ending(35, 2, CH_A_ACUTE, u("m"), 0, 0, 0);
        add_ending(36, 2, u("o"), u("s"), 0, 0, 0);
        add_ending(37, 2, u("u"), u("s"), 0, 0, 0);
        add_ending(38, 2, CH_Y_ACUTE, u("m"), 0, 0, 0);
        add_ending(39, 2, u("m"), u("i"), 0, 0, 0);
        add_ending(40, 2, u("o"), u("u"), 0, 0, 0);
        add_ending(41, 1, u("a"), 0, 0, 0, 0);
        add_ending(42, 1, u("e"), 0, 0, 0, 0);
        add_ending(43, 1, u("i"), 0, 0, 0, 0);
        add_ending(44, 1, u("o"), 0, 0, 0, 0);
        add_ending(45, 1, u("u"), 0, 0, 0, 0);
        add_ending(46, 1, CH_U_RING, 0, 0, 0, 0);
        add_ending(47, 1, u("y"), 0, 0, 0, 0);
        add_ending(48, 1, CH_A_ACUTE, 0, 0, 0, 0);
        add_ending(49, 1, CH_E_ACUTE, 0, 0, 0, 0);
        add_ending(50, 1, CH_I_ACUTE, 0, 0, 0, 0);
        add_ending(51, 1, CH_Y_ACUTE, 0, 0, 0, 0);
        add_ending(52, 1, CH_E_CARON, 0, 0, 0, 0);
    end

    function automatic bit tail_is(input logic [15:0] w [WIN], input int stop, input int len,
                                   input logic [15:0] pat [5], input int n);
        if (len < n || stop - n < 0)
            return 0;
        for (int j = 0; j < n; j++)
        begin
            if (w[stop - n + j] != pat[j])
                return 0;
        end
        return 1;
    endfunction

    // Takes one character; returns 1 with the stem in result on the last one.
    function automatic bit stem_char(input logic [15:0] code, input logic last,
                                     output czs_out_t result);
        logic [15:0] w [WIN];
        logic [15:0] pat [5];
        logic [15:0] p;
        logic [15:0] l;
        int len;
        int stop;
        result = '0;
        for (int k = WIN - 1; k > 0; k--)
            tail_chars[k] = tail_chars[k - 1];
        tail_chars[0] = code;
        if (char_count < MAX_WORD_LENGTH)
            char_count++;
        if (!last)
            return 0;
        for (int k = 0; k < WIN; k++)
            w[WIN - 1 - k] = tail_chars[k];
        len = char_count;
        stop = WIN;
        for (int i = 0; i < N_ENDINGS; i++)
        begin
            pat = endings[i];
            if (len > ending_len[i] + 2 && tail_is(w, stop, len, pat, ending_len[i]))
            begin
                len -= ending_len[i];
                stop -= ending_len[i];
                break;
            end
        end
        if (len > 5)
        begin
            pat = '{u("o"), u("v"), 0, 0, 0};
            if (tail_is(w, stop, len, pat, 2))
                stop = -stop;
            pat = '{u("i"), u("n"), 0, 0, 0};
            if (stop > 0 && tail_is(w, stop, len, pat, 2))
                stop = -stop;
            pat = '{CH_U_RING, u("v"), 0, 0, 0};
            if (stop > 0 && tail_is(w, stop, len, pat, 2))
                stop = -stop;
            if (stop < 0)
            begin
                stop = -stop - 2;
                len -= 2;
            end
        end
        if (len > 0 && stop >= 2)
        begin
            p = w[stop - 2];
            l = w[stop - 1];
            if (len >= 2 && l == u("t") && p == CH_C_CARON)
            begin
                w[stop - 2] = u("c");
                w[stop - 1] = u("k");
            end
            else if (len >= 2 && l == u("t") && p == CH_S_CARON)
            begin
                w[stop - 2] = u("s");
                w[stop - 1] = u("k");
            end
            else if (l == u("c") || l == CH_C_CARON)
                w[stop - 1] = u("k");
            else if (l == u("z") || l == CH_Z_CARON)
                w[stop - 1] = u("h");
            else if (len > 1 && p == u("e"))
            begin
                w[stop - 2] = l;
                len--;
                stop--;
            end
            else if (len > 2 && p == CH_U_RING)
                w[stop - 2] = u("o");
        end
        result.stem_length = (len > 255) ? 8'd255 : len[7:0];
        result.stem_last_char = (len >= 1 && stop >= 1) ? w[stop - 1] : 16'd0;
        result.stem_prev_char = (len >= 2 && stop >= 2) ? w[stop - 2] : 16'd0;
        for (int k = 0; k < WIN; k++)
            tail_chars[k] = '0;
        char_count = 0;
        return 1;
    endfunction

    function automatic logic [15:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return u(8'h61 + 8'($urandom_range(0, 25)));
        else if (r < 9)
        begin
            case ($urandom_range(0, 8))
                0: return CH_A_ACUTE;
                1: return CH_E_ACUTE;
                2: return CH_I_ACUTE;
                3: return CH_Y_ACUTE;
                4: return CH_C_CARON;
                5: return CH_E_CARON;
                6: return CH_S_CARON;
                7: return CH_U_RING;
                default: return CH_Z_CARON;
            endcase
        end
        return 16'($urandom());
    endfunction

    task automatic push_char(input logic [15:0] code, input logic last);
        stim_row_t row;
        row.code = code;
        row.last = last;
        row.known = 0;
        row.want = '0;
        requests.push_back(row);
    endtask

    task automatic push_word(input string text);
        for (int i = 0; i < text.len(); i++)
            push_char(u(text[i]), i == text.len() - 1);
    endtask

    task automatic push_known(input logic [15:0] code, input logic [7:0] n,
                              input logic [15:0] last_c, input logic [15:0] prev_c);
        stim_row_t row;
        row.code = code;
        row.last = 1;
        row.known = 1;
        row.want = '{n, last_c, prev_c};
        requests.push_back(row);
    endtask

    task automatic build_directed();
        push_known(16'h0000, 8'd1, 16'h0000, 16'h0000);
        push_known(16'hFFFF, 8'd1, 16'hFFFF, 16'h0000);
        push_word("zatech");
        push_word("mestem");
        push_word("hradech");
        push_word("otcovi");
        push_word("bratrovi");
        push_word("matkin");
        push_word("zamecnik");
        push_word("pes");
        push_char(u("k"), 0);
        push_char(u("l"), 0);
        push_char(u("i"), 0);
        push_char(u("c"), 1);
        push_char(u("m"), 0);
        push_char(CH_U_RING, 0);
        push_char(u("j"), 1);
        push_char(u("p"), 0);
        push_char(u("e"), 0);
        push_char(CH_C_CARON, 0);
        push_char(u("t"), 1);
        for (int i = 0; i < 300; i++)
            push_char(16'h5555 ^ 16'(i), 0);
        push_char(16'hAAAA, 1);
    endtask

    task automatic build_random();
        int n;
        int e;
        int total;
        logic [15:0] word [$];
        total = 0;
        while (total < N_RANDOM)
        begin
            word.delete();
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40)
                                              : $urandom_range(1, 9);
            for (int i = 0; i < n; i++)
                word.push_back(pick_char());
            if ($urandom_range(0, 9) < 7)
            begin
                e = $urandom_range(0, N_ENDINGS - 1);
                for (int i = 0; i < ending_len[e]; i++)
                    word.push_back(endings[e][i]);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: word.push_back(u("o"));
                    1: word.push_back(u("i"));
                    default: word.push_back(CH_U_RING);
                endcase
                word.push_back(($urandom_range(0, 2) == 0) ? u("n") : u("v"));
            end
            for (int i = 0; i < word.size(); i++)
                push_char(word[i], i == word.size() - 1);
            total += word.size();
        end
    endtask

    initial
    begin
        stim_row_t row;
        czs_out_t stem;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        errors = 0;
        mismatches = 0;
        calm = 0;
        hold_off = 0;
        sending_done = 0;
        char_count = 0;
        for (int k = 0; k < WIN; k++)
            tail_chars[k] = '0;
        #1;
        build_directed();
        build_random();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (requests.size() > 0)
        begin
            row = requests.pop_front();
            if (requests.size() < CALM_ITEMS)
                calm = 1;
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data <= '{row.code, row.last};
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            if (stem_char(row.code, row.last, stem))
            begin
                if (row.known && stem != row.want)
                begin
                    errors++;
                    $display("directed row expects %h, stemmer model gives %h",
                             row.want, stem);
                end
                stems_due.push_back(stem);
            end
        end
        in_valid <= 1'b0;
        sending_done = 1;
    end

    initial
    begin
        #2000;
        @(posedge clk);
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
        begin
            out_ready <= 1'b0;
            ready_gap = 0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else if (ready_gap > 0)
        begin
            ready_gap--;
            out_ready <= (ready_gap == 0);
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            ready_gap = $urandom_range(1, 5);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        czs_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (stems_due.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected stem %h", out_data);
            end
            else
            begin
                want = stems_due.pop_front();
                if (out_data.stem_length != want.stem_length
                    || out_data.stem_last_char != want.stem_last_char
                    || out_data.stem_prev_char != want.stem_prev_char)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("stem mismatch: expected %0d %h %h, got %0d %h %h",
                                 want.stem_length, want.stem_last_char,
                                 want.stem_prev_char, out_data.stem_length,
                                 out_data.stem_last_char, out_data.stem_prev_char);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        wait (sending_done);
        while (stems_due.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/czs_pkg.sv
rtl/core/czs_cell.sv
rtl/core/czs_stem.sv
rtl/core/czech_suffix_stemmer.sv
bench/czech_suffix_stemmer_tb.sv
